### sv/pge_pkg.sv
// Shared types for the pheromone grid engine: cell word and walker controls.
`timescale 1ns / 1ps

package pge_pkg;

  localparam int unsigned ValW = 16;

  typedef struct packed {
    logic [ValW-1:0] lost;
    logic [ValW-1:0] nest;
    logic [ValW-1:0] food;
  } cell_t;

  typedef struct packed {
    logic start;
    logic step;
  } walk_ctl_t;

endpackage

### sv/pge_store.sv
// Cell store: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module pge_store
  import pge_pkg::*;
#(
  parameter int unsigned AW    = 16,
  parameter int unsigned DEPTH = 65536
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  cell_t         wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output cell_t         rdata_o
);

  cell_t mem [DEPTH];
  cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/pge_walker.sv
// Row and column walker that steps through a rectangle of cells.
`timescale 1ns / 1ps

module pge_walker
  import pge_pkg::*;
#(
  parameter int unsigned RW = 8,
  parameter int unsigned CW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  walk_ctl_t     ctl_i,
  input  logic [RW-1:0] last_row_i,
  input  logic [CW-1:0] last_col_i,
  output logic [RW-1:0] row_o,
  output logic [CW-1:0] col_o,
  output logic          last_o
);

  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic          col_end;

  assign col_end = (col_q == last_col_i);
  assign last_o  = col_end && (row_q == last_row_i);

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    priority if (ctl_i.start) begin
      row_d = '0;
      col_d = '0;
    end else if (ctl_i.step) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  assign row_o = row_q;
  assign col_o = col_q;

endmodule

### sv/pheromone_grid_engine.sv
// Top level of the pheromone grid engine: command decode, read-modify-write and sweeps.
`timescale 1ns / 1ps

// Point commands (deposit, subtract, set, read colour) on a cell in range make one memory
// read, then the write-back or the result load; a read colour waits further while the
// result register is still full. Ticks without evaporation, unused kinds and cells out
// of range do not leave the idle state. An evaporation sweep visits width * height cells,
// one cell per cycle through the single read and write port of the cell store. Clear
// writes zero to all MAX_HEIGHT * 2**ceil(log2(MAX_WIDTH)) cells (65536 at the default
// size), as does the clearing pass after reset; no request is accepted during either.
module pheromone_grid_engine
  import pge_pkg::*;
#(
  parameter int unsigned MAX_WIDTH        = 256,
  parameter int unsigned MAX_HEIGHT       = 256,
  parameter int unsigned LOST_DECAY_SHIFT = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // col[15:0], row[31:16], amount[47:32]
  input  logic [4:0]  s_axis_tuser,   // kind[2:0], channel[4:3]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16], alpha[31:24]
);

  localparam int unsigned CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned AW    = RW + CW;
  localparam int unsigned DEPTH = MAX_HEIGHT * (2 ** CW);
  localparam int unsigned LRW   = ValW + LOST_DECAY_SHIFT;
  localparam logic [RW-1:0] ClrLastRow = RW'(MAX_HEIGHT - 1);
  localparam logic [15:0]   MaxW16     = 16'(MAX_WIDTH);
  localparam logic [15:0]   MaxH16     = 16'(MAX_HEIGHT);

  localparam logic [2:0] KIND_DEPOSIT  = 3'd0;
  localparam logic [2:0] KIND_SUBTRACT = 3'd1;
  localparam logic [2:0] KIND_SET      = 3'd2;
  localparam logic [2:0] KIND_TICK     = 3'd3;
  localparam logic [2:0] KIND_CLEAR    = 3'd4;
  localparam logic [2:0] KIND_READ     = 3'd5;

  localparam logic [1:0] CH_FOOD = 2'd0;
  localparam logic [1:0] CH_NEST = 2'd1;
  localparam logic [1:0] CH_LOST = 2'd2;

  localparam logic [1:0] REG_GRID_WIDTH   = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_DECAY_RATE   = 2'd2;
  localparam logic [1:0] REG_DECAY_PERIOD = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_HOLD,
    ST_SWEEP,
    ST_DRAIN
  } state_e;

  logic [8:0]  grid_width_q, grid_height_q;
  logic [15:0] decay_rate_q;
  logic [9:0]  decay_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q   <= 9'd256;
      grid_height_q  <= 9'd256;
      decay_rate_q   <= 16'd256;
      decay_period_q <= 10'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_GRID_WIDTH:   grid_width_q   <= cfg_wdata_i[8:0];
        REG_GRID_HEIGHT:  grid_height_q  <= cfg_wdata_i[8:0];
        REG_DECAY_RATE:   decay_rate_q   <= cfg_wdata_i;
        REG_DECAY_PERIOD: decay_period_q <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  logic [2:0]  in_kind;
  logic [1:0]  in_ch;
  logic [15:0] in_col, in_row, in_amt;
  assign in_kind = s_axis_tuser[2:0];
  assign in_ch   = s_axis_tuser[4:3];
  assign in_col  = s_axis_tdata[15:0];
  assign in_row  = s_axis_tdata[31:16];
  assign in_amt  = s_axis_tdata[47:32];

  logic [15:0] w_eff, h_eff, w_m1, h_m1;
  logic        in_range;
  logic [AW-1:0] in_addr;
  assign w_eff = ({7'd0, grid_width_q} > MaxW16) ? MaxW16 : {7'd0, grid_width_q};
  assign h_eff = ({7'd0, grid_height_q} > MaxH16) ? MaxH16 : {7'd0, grid_height_q};
  assign w_m1  = w_eff - 16'd1;
  assign h_m1  = h_eff - 16'd1;
  assign in_range = !in_col[15] && !in_row[15] && (in_col < w_eff) && (in_row < h_eff);
  assign in_addr  = {in_row[RW-1:0], in_col[CW-1:0]};

  state_e        state_q;
  logic [2:0]    op_kind_q;
  logic [1:0]    op_ch_q;
  logic [15:0]   op_amt_q;
  logic [AW-1:0] op_addr_q;
  logic [9:0]    tick_q;
  logic          wr_pend_q;
  logic [AW-1:0] wr_addr_q;
  logic          m_valid_q;
  logic [31:0]   m_data_q;

  walk_ctl_t     walk_ctl;
  logic [RW-1:0] walk_row, walk_last_row;
  logic [CW-1:0] walk_col, walk_last_col;
  logic          walk_last;
  logic [AW-1:0] walk_addr;
  assign walk_addr = {walk_row, walk_col};

  logic          accept, out_free, point_hit, read_hit, sweep_due, size_nz;
  logic [9:0]    tick_inc;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_valid_q || m_axis_tready;
  assign point_hit = in_range && (in_ch != 2'd3) &&
                     (in_kind == KIND_DEPOSIT || in_kind == KIND_SUBTRACT ||
                      in_kind == KIND_SET);
  assign read_hit  = in_range && (in_kind == KIND_READ);
  assign tick_inc  = tick_q + 10'd1;
  assign sweep_due = (tick_inc >= decay_period_q);
  assign size_nz   = (w_eff != 16'd0) && (h_eff != 16'd0);

  assign walk_last_row = (state_q == ST_CLEAR) ? ClrLastRow : h_m1[RW-1:0];
  assign walk_last_col = (state_q == ST_CLEAR) ? '1 : w_m1[CW-1:0];
  assign walk_ctl.start = accept && ((in_kind == KIND_CLEAR) ||
                                     (in_kind == KIND_TICK && sweep_due && size_nz));
  assign walk_ctl.step  = (state_q == ST_CLEAR) || (state_q == ST_SWEEP);

  pge_walker #(
    .RW (RW),
    .CW (CW)
  ) u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (walk_ctl),
    .last_row_i (walk_last_row),
    .last_col_i (walk_last_col),
    .row_o      (walk_row),
    .col_o      (walk_col),
    .last_o     (walk_last)
  );

  cell_t         rdata, rmw_cell, dec_cell, mem_wdata;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;

  pge_store #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  logic [LRW-1:0] lost_rate, lost_ext;
  assign lost_rate = LRW'(decay_rate_q) << LOST_DECAY_SHIFT;
  assign lost_ext  = LRW'(rdata.lost);

  always_comb begin
    dec_cell.food = (rdata.food > decay_rate_q) ? (rdata.food - decay_rate_q) : '0;
    dec_cell.nest = (rdata.nest > decay_rate_q) ? (rdata.nest - decay_rate_q) : '0;
    dec_cell.lost = (lost_ext > lost_rate) ? ValW'(lost_ext - lost_rate) : '0;
  end

  logic [15:0] old_val, new_val;
  always_comb begin
    unique case (op_ch_q)
      CH_FOOD: old_val = rdata.food;
      CH_NEST: old_val = rdata.nest;
      default: old_val = rdata.lost;
    endcase
    unique case (op_kind_q)
      KIND_DEPOSIT:  new_val = (op_amt_q > old_val) ? op_amt_q : old_val;
      KIND_SUBTRACT: new_val = (old_val > op_amt_q) ? (old_val - op_amt_q) : '0;
      default:       new_val = op_amt_q;
    endcase
    rmw_cell = rdata;
    unique case (op_ch_q)
      CH_FOOD: rmw_cell.food = new_val;
      CH_NEST: rmw_cell.nest = new_val;
      default: rmw_cell.lost = new_val;
    endcase
  end

  logic [7:0] r_raw, g_raw, b_raw, r_px, g_px, b_px, a_px;
  logic [9:0] px_sum;
  always_comb begin
    r_raw = rdata.lost[15:8];
    g_raw = rdata.food[15:8];
    b_raw = rdata.nest[15:8];
    if (r_raw > g_raw) begin
      r_px = r_raw;
      g_px = '0;
      b_px = '0;
    end else begin
      r_px = '0;
      g_px = g_raw;
      b_px = b_raw;
    end
    px_sum = 10'(r_px) + 10'(g_px) + 10'(b_px);
    a_px   = (px_sum > 10'd255) ? 8'd255 : px_sum[7:0];
  end

  logic rmw_write;
  assign rmw_write = (state_q == ST_RMW) && (op_kind_q != KIND_READ);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = op_addr_q;
    mem_wdata = rmw_cell;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = walk_addr;
        mem_wdata = '0;
      end
      ST_RMW: mem_we = rmw_write;
      ST_SWEEP, ST_DRAIN: begin
        mem_we    = wr_pend_q;
        mem_waddr = wr_addr_q;
        mem_wdata = dec_cell;
      end
      default: ;
    endcase
    mem_re    = (state_q == ST_SWEEP) || (accept && (point_hit || read_hit));
    mem_raddr = (state_q == ST_SWEEP) ? walk_addr : in_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      op_kind_q <= KIND_DEPOSIT;
      op_ch_q   <= CH_FOOD;
      op_amt_q  <= '0;
      op_addr_q <= '0;
      tick_q    <= '0;
      wr_pend_q <= 1'b0;
      wr_addr_q <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      wr_pend_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          if (walk_last) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op_kind_q <= in_kind;
            op_ch_q   <= in_ch;
            op_amt_q  <= in_amt;
            op_addr_q <= in_addr;
            if (point_hit || read_hit) begin
              state_q <= ST_RMW;
            end else if (in_kind == KIND_CLEAR) begin
              state_q <= ST_CLEAR;
            end else if (in_kind == KIND_TICK) begin
              if (sweep_due) begin
                tick_q <= '0;
                if (size_nz) begin
                  state_q <= ST_SWEEP;
                end
              end else begin
                tick_q <= tick_inc;
              end
            end
          end
        end
        ST_RMW, ST_HOLD: begin
          if (op_kind_q != KIND_READ) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {a_px, b_px, g_px, r_px};
            state_q   <= ST_IDLE;
          end else begin
            state_q <= ST_HOLD;
          end
        end
        ST_SWEEP: begin
          wr_pend_q <= 1'b1;
          wr_addr_q <= walk_addr;
          if (walk_last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_no_write_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !mem_we && !wr_pend_q)
    else $error("cell store written while requests are accepted");

  a_hold_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOLD) |-> m_valid_q)
    else $error("colour held with empty result register");

  a_sweep_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && wr_pend_q) |-> (wr_addr_q != walk_addr))
    else $error("sweep read and write hit the same cell");

  a_drain_after_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> wr_pend_q && ($past(state_q) == ST_SWEEP))
    else $error("drain without pending sweep write");

endmodule
